### rtl/lppd_pkg.sv
`timescale 1ns / 1ps

package lppd_pkg;

    localparam int MAX_BLOBS_DEF    = 8;
    localparam int COORD_BITS_DEF   = 10;
    localparam int CORDIC_ITERS_DEF = 14;

    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_LIMIT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTION_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_DEPTH     = 3'd6;

    localparam logic [CFG_W-1:0] SCALE_RESET = 24'd65536;
    localparam logic [CFG_W-1:0] M24         = 24'hFFFFFF;

    localparam logic signed [16:0] ANG_LIM  = 17'sd25736;
    localparam logic [15:0]        INV_GAIN = 16'd39797;

    typedef struct packed {
        logic [CFG_W-1:0] scale_factor;
        logic [CFG_W-1:0] grid_size;
        logic [CFG_W-1:0] leg_limit;
        logic [CFG_W-1:0] detection_width;
        logic [CFG_W-1:0] detection_depth;
        logic [CFG_W-1:0] bound_width;
        logic [CFG_W-1:0] bound_depth;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [23:0] person_x;
        logic signed [23:0] person_y;
        logic signed [15:0] angle;
        logic [23:0]        magnitude;
        logic [4:0]         person_count;
        logic [4:0]         count_in_bound;
        logic [4:0]         closest_index;
        logic               closest_valid;
        logic               overflow;
        logic               last;
    } result_t;

    typedef enum logic [2:0] {
        F_LOAD,
        F_READ,
        F_MUL,
        F_SQR,
        F_TEST,
        F_END
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_MUL,
        B_OUT,
        B_SUM
    } back_state_t;

    // atan(2^-i) in Q1.14, rounded.
    function automatic logic signed [15:0] atan_q14(input logic [4:0] i);
        logic signed [15:0] r;
        case (i)
            5'd0:    r = 16'sd12868;
            5'd1:    r = 16'sd7596;
            5'd2:    r = 16'sd4014;
            5'd3:    r = 16'sd2037;
            5'd4:    r = 16'sd1023;
            5'd5:    r = 16'sd512;
            5'd6:    r = 16'sd256;
            5'd7:    r = 16'sd128;
            5'd8:    r = 16'sd64;
            5'd9:    r = 16'sd32;
            5'd10:   r = 16'sd16;
            5'd11:   r = 16'sd8;
            5'd12:   r = 16'sd4;
            5'd13:   r = 16'sd2;
            5'd14:   r = 16'sd1;
            default: r = 16'sd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/lppd_ram.sv
`timescale 1ns / 1ps

module lppd_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a <= mem_reg[raddr_a];
        rdata_b <= mem_reg[raddr_b];
    end

endmodule

### rtl/lppd_fifo.sv
`timescale 1ns / 1ps

module lppd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/lppd_front.sv
`timescale 1ns / 1ps

module lppd_front #(
    parameter int MAX_BLOBS  = lppd_pkg::MAX_BLOBS_DEF,
    parameter int COORD_BITS = lppd_pkg::COORD_BITS_DEF,
    localparam int P_W   = COORD_BITS + 21,
    localparam int REC_W = 2 + 2 * P_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lppd_pkg::cfg_t    cfg,
    input  logic              push,
    output logic              full,
    input  logic [9:0]        blob_x,
    input  logic [9:0]        blob_y,
    input  logic              last_blob,
    output logic              q_push,
    output logic [REC_W-1:0]  q_data,
    input  logic              q_full
);

    localparam int CNT_W = $clog2(MAX_BLOBS + 1);
    localparam int IDX_W = $clog2(MAX_BLOBS);
    localparam int CW    = COORD_BITS;
    localparam int MID_W = COORD_BITS + 20;
    localparam int BX    = P_W + 2;

    lppd_pkg::front_state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] i_reg, i_next, j_reg, j_next;
    logic             ovf_reg, ovf_next;

    logic             accept, can_store;
    logic [CNT_W-1:0] cnt_after;
    logic [CW-1:0]    cx_in, cy_in;
    logic [2*CW-1:0]  rd_a, rd_b;
    logic [CW-1:0]    ax, ay, bx, by, adx, ady;
    logic [CW:0]      sum_x, sum_y;

    logic [CW+23:0]   dxp_reg, dyp_reg;
    logic [CW+24:0]   sxp_reg, syp_reg;
    logic [MID_W-1:0] dxs, dys, mid_x, mid_y;
    logic [23:0]      dist_x, dist_y;
    logic [22:0]      half;
    logic [47:0]      sqx_reg, sqy_reg, lim2_reg;
    logic signed [P_W-1:0] px_reg, py_reg;

    logic                 close, in_win, pair_last, found;
    logic signed [BX-1:0] x2, wlim, dlim, ybx;

    assign accept    = push && !full;
    assign full      = (state_reg != lppd_pkg::F_LOAD);
    assign can_store = (cnt_reg < CNT_W'(MAX_BLOBS));
    assign cnt_after = can_store ? cnt_reg + 1'b1 : cnt_reg;
    assign cx_in     = CW'(blob_x);
    assign cy_in     = CW'(blob_y);

    lppd_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_BLOBS)
    ) u_store (
        .clk     (clk),
        .we      (accept && can_store),
        .waddr   (cnt_reg[IDX_W-1:0]),
        .wdata   ({cx_in, cy_in}),
        .raddr_a (i_reg[IDX_W-1:0]),
        .rdata_a (rd_a),
        .raddr_b (j_reg[IDX_W-1:0]),
        .rdata_b (rd_b)
    );

    assign ax    = rd_a[2*CW-1:CW];
    assign ay    = rd_a[CW-1:0];
    assign bx    = rd_b[2*CW-1:CW];
    assign by    = rd_b[CW-1:0];
    assign adx   = (ax > bx) ? ax - bx : bx - ax;
    assign ady   = (ay > by) ? ay - by : by - ay;
    assign sum_x = {1'b0, ax} + {1'b0, bx};
    assign sum_y = {1'b0, ay} + {1'b0, by};

    assign dxs    = dxp_reg[CW+23:4];
    assign dys    = dyp_reg[CW+23:4];
    assign dist_x = (dxs > MID_W'(lppd_pkg::M24)) ? lppd_pkg::M24 : dxs[23:0];
    assign dist_y = (dys > MID_W'(lppd_pkg::M24)) ? lppd_pkg::M24 : dys[23:0];
    assign mid_x  = sxp_reg[CW+24:5];
    assign mid_y  = syp_reg[CW+24:5];
    assign half   = cfg.grid_size[23:1];

    assign close  = ({1'b0, sqx_reg} + {1'b0, sqy_reg}) < {1'b0, lim2_reg};
    assign x2     = BX'(px_reg) <<< 1;
    assign ybx    = BX'(py_reg);
    assign wlim   = $signed(BX'(cfg.detection_width));
    assign dlim   = $signed(BX'(cfg.detection_depth));
    assign in_win = (x2 >= -wlim) && (x2 <= wlim) && (ybx >= 0) && (ybx <= dlim);
    assign found  = close && in_win;

    assign pair_last = !((j_reg + 1'b1) < cnt_reg) && !((i_reg + 2'd2) < cnt_reg);

    // Pair pipeline registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == lppd_pkg::F_MUL)
        begin
            dxp_reg <= (CW+24)'(adx) * (CW+24)'(cfg.scale_factor);
            dyp_reg <= (CW+24)'(ady) * (CW+24)'(cfg.scale_factor);
            sxp_reg <= (CW+25)'(sum_x) * (CW+25)'(cfg.scale_factor);
            syp_reg <= (CW+25)'(sum_y) * (CW+25)'(cfg.scale_factor);
        end
        if (state_reg == lppd_pkg::F_SQR)
        begin
            sqx_reg  <= 48'(dist_x) * 48'(dist_x);
            sqy_reg  <= 48'(dist_y) * 48'(dist_y);
            lim2_reg <= 48'(cfg.leg_limit) * 48'(cfg.leg_limit);
            px_reg   <= $signed(P_W'(half)) - $signed(P_W'(mid_x));
            py_reg   <= $signed(P_W'(mid_y)) - $signed(P_W'(half));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lppd_pkg::F_LOAD;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ovf_next   = ovf_reg;
        q_push     = 1'b0;
        q_data     = {1'b0, 1'b0, px_reg, py_reg};
        case (state_reg)
            lppd_pkg::F_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = cnt_after;
                    if (!can_store)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_blob)
                    begin
                        i_next     = '0;
                        j_next     = CNT_W'(1);
                        state_next = (cnt_after >= CNT_W'(2)) ? lppd_pkg::F_READ
                                                              : lppd_pkg::F_END;
                    end
                end
            end
            lppd_pkg::F_READ: state_next = lppd_pkg::F_MUL;
            lppd_pkg::F_MUL:  state_next = lppd_pkg::F_SQR;
            lppd_pkg::F_SQR:  state_next = lppd_pkg::F_TEST;
            lppd_pkg::F_TEST:
            begin
                if (!(found && q_full))
                begin
                    q_push = found;
                    if (pair_last)
                    begin
                        state_next = lppd_pkg::F_END;
                    end
                    else
                    begin
                        state_next = lppd_pkg::F_READ;
                        if ((j_reg + 1'b1) < cnt_reg)
                        begin
                            j_next = j_reg + 1'b1;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                            j_next = i_reg + 2'd2;
                        end
                    end
                end
            end
            lppd_pkg::F_END:
            begin
                q_data = {1'b1, ovf_reg, {(2 * P_W){1'b0}}};
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = lppd_pkg::F_LOAD;
                end
            end
            default: state_next = lppd_pkg::F_LOAD;
        endcase
    end

endmodule

### rtl/lppd_back.sv
`timescale 1ns / 1ps

module lppd_back #(
    parameter int COORD_BITS   = lppd_pkg::COORD_BITS_DEF,
    parameter int CORDIC_ITERS = lppd_pkg::CORDIC_ITERS_DEF,
    localparam int P_W   = COORD_BITS + 21,
    localparam int REC_W = 2 + 2 * P_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lppd_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  logic [REC_W-1:0]   q_data,
    output logic               q_pop,
    output logic               o_push,
    output lppd_pkg::result_t  o_data,
    input  logic               o_full
);

    localparam int CW     = P_W + 2;
    localparam int BX     = P_W + 2;
    localparam int ITER_W = $clog2(CORDIC_ITERS);

    lppd_pkg::back_state_t state_reg, state_next;

    logic                  rec_end, rec_ovf;
    logic signed [P_W-1:0] rec_px, rec_py;

    logic signed [P_W-1:0] px_reg, py_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg, sx, sy;
    logic signed [16:0]    z_reg;
    logic [ITER_W-1:0]     k_reg;
    logic                  origin_reg, inb_reg, ovf_reg;
    logic [CW+15:0]        mp_reg;

    logic [4:0]  n_reg, nb_reg, best_reg;
    logic        have_reg;
    logic [23:0] best_mag_reg;

    logic                 inb;
    logic signed [BX-1:0] x2, wlim, dlim, ybx;
    logic [CW-1:0]        mag_full;
    logic [23:0]          mag;
    logic signed [15:0]   ang;
    logic signed [15:0]   step_ang;
    logic                 better;

    function automatic logic signed [23:0] sat24(input logic signed [P_W-1:0] v);
        logic signed [23:0] r;
        if (v > $signed(P_W'(24'sh7FFFFF)))
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < $signed(P_W'(24'sh800000)))
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign rec_end = q_data[2*P_W+1];
    assign rec_ovf = q_data[2*P_W];
    assign rec_px  = q_data[2*P_W-1:P_W];
    assign rec_py  = q_data[P_W-1:0];

    assign x2   = BX'(rec_px) <<< 1;
    assign ybx  = BX'(rec_py);
    assign wlim = $signed(BX'(cfg.bound_width));
    assign dlim = $signed(BX'(cfg.bound_depth));
    assign inb  = (x2 >= -wlim) && (x2 <= wlim) && (ybx >= 0) && (ybx <= dlim);

    assign sx       = cy_reg >>> k_reg;
    assign sy       = cx_reg >>> k_reg;
    assign step_ang = lppd_pkg::atan_q14(5'(k_reg));

    assign mag_full = CW'(mp_reg >> 16);
    assign mag = origin_reg ? 24'd0
               : (mag_full > CW'(lppd_pkg::M24)) ? lppd_pkg::M24 : mag_full[23:0];
    assign ang = origin_reg ? 16'sd0
               : (z_reg > lppd_pkg::ANG_LIM)  ? lppd_pkg::ANG_LIM[15:0]
               : (z_reg < -lppd_pkg::ANG_LIM) ? -lppd_pkg::ANG_LIM[15:0]
               : z_reg[15:0];
    assign better = !have_reg || (mag < best_mag_reg);

    // CORDIC and magnitude datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            lppd_pkg::B_IDLE:
            begin
                px_reg     <= rec_px;
                py_reg     <= rec_py;
                cx_reg     <= CW'(rec_py);
                cy_reg     <= CW'(rec_px);
                z_reg      <= '0;
                origin_reg <= (rec_px == '0) && (rec_py == '0);
                inb_reg    <= inb;
                ovf_reg    <= rec_ovf;
            end
            lppd_pkg::B_ROT:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg <= cx_reg + sx;
                    cy_reg <= cy_reg - sy;
                    z_reg  <= z_reg + 17'(step_ang);
                end
                else
                begin
                    cx_reg <= cx_reg - sx;
                    cy_reg <= cy_reg + sy;
                    z_reg  <= z_reg - 17'(step_ang);
                end
            end
            lppd_pkg::B_MUL:
            begin
                mp_reg <= cx_reg[CW-1] ? '0
                        : (CW+16)'(cx_reg[CW-2:0]) * (CW+16)'(lppd_pkg::INV_GAIN)
                          + (CW+16)'(32768);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lppd_pkg::B_IDLE;
            k_reg        <= '0;
            n_reg        <= '0;
            nb_reg       <= '0;
            best_reg     <= '0;
            have_reg     <= 1'b0;
            best_mag_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                lppd_pkg::B_IDLE: k_reg <= '0;
                lppd_pkg::B_ROT:  k_reg <= k_reg + 1'b1;
                lppd_pkg::B_OUT:
                begin
                    if (!o_full)
                    begin
                        n_reg <= n_reg + 1'b1;
                        if (inb_reg)
                        begin
                            nb_reg <= nb_reg + 1'b1;
                            if (better)
                            begin
                                have_reg     <= 1'b1;
                                best_mag_reg <= mag;
                                best_reg     <= n_reg;
                            end
                        end
                    end
                end
                lppd_pkg::B_SUM:
                begin
                    if (!o_full)
                    begin
                        n_reg    <= '0;
                        nb_reg   <= '0;
                        best_reg <= '0;
                        have_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        o_push     = 1'b0;
        o_data     = '0;
        case (state_reg)
            lppd_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = rec_end ? lppd_pkg::B_SUM : lppd_pkg::B_ROT;
                end
            end
            lppd_pkg::B_ROT:
            begin
                if (k_reg == ITER_W'(CORDIC_ITERS - 1))
                begin
                    state_next = lppd_pkg::B_MUL;
                end
            end
            lppd_pkg::B_MUL: state_next = lppd_pkg::B_OUT;
            lppd_pkg::B_OUT:
            begin
                o_data.person_x  = sat24(px_reg);
                o_data.person_y  = sat24(py_reg);
                o_data.angle     = ang;
                o_data.magnitude = mag;
                if (!o_full)
                begin
                    o_push     = 1'b1;
                    state_next = lppd_pkg::B_IDLE;
                end
            end
            lppd_pkg::B_SUM:
            begin
                o_data.kind           = 1'b1;
                o_data.person_count   = n_reg;
                o_data.count_in_bound = nb_reg;
                o_data.closest_index  = have_reg ? best_reg : 5'd0;
                o_data.closest_valid  = have_reg;
                o_data.overflow       = ovf_reg;
                o_data.last           = 1'b1;
                if (!o_full)
                begin
                    o_push     = 1'b1;
                    state_next = lppd_pkg::B_IDLE;
                end
            end
            default: state_next = lppd_pkg::B_IDLE;
        endcase
    end

endmodule

### rtl/leg_pair_person_detector.sv
`timescale 1ns / 1ps
// After the last blob of a frame, each stored pair passes through the pair tester's read,
// multiply, square and test steps, and each person found goes through the shared CORDIC
// rotations, gain multiply and output step before its result request is queued; the summary follows.
// Throughput: blobs load one per cycle while full is low; full stays high while a frame's
// pairs are searched, and the single pair tester and CORDIC unit bound the frame end.
// Reset (asynchronous, active low) empties the blob store, the queues and the frame counts.
module leg_pair_person_detector #(
    parameter int MAX_BLOBS    = lppd_pkg::MAX_BLOBS_DEF,
    parameter int COORD_BITS   = lppd_pkg::COORD_BITS_DEF,
    parameter int CORDIC_ITERS = lppd_pkg::CORDIC_ITERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [9:0]                        blob_x,
    input  logic [9:0]                        blob_y,
    input  logic                              last_blob,
    output logic                              empty,
    input  logic                              pop,
    output logic                              kind,
    output logic signed [23:0]                person_x,
    output logic signed [23:0]                person_y,
    output logic signed [15:0]                angle,
    output logic [23:0]                       magnitude,
    output logic [4:0]                        person_count,
    output logic [4:0]                        count_in_bound,
    output logic [4:0]                        closest_index,
    output logic                              closest_valid,
    output logic                              overflow,
    output logic                              last,
    input  logic                              cfg_we,
    input  logic [lppd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lppd_pkg::CFG_W-1:0]        cfg_wdata
);

    // Candidate records carry the exact, unsaturated person position.
    localparam int P_W   = COORD_BITS + 21;
    localparam int REC_W = 2 + 2 * P_W;

    lppd_pkg::cfg_t    cfg_reg;
    logic              q_push, q_full, q_pop, q_empty;
    logic [REC_W-1:0]  q_wdata, q_rdata;
    logic              o_push, o_full;
    lppd_pkg::result_t o_wdata, o_rdata;

    // The configuration registers are shared by the pair tester and the CORDIC back end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.scale_factor <= lppd_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lppd_pkg::CFG_SCALE_FACTOR:    cfg_reg.scale_factor    <= cfg_wdata;
                lppd_pkg::CFG_GRID_SIZE:       cfg_reg.grid_size       <= cfg_wdata;
                lppd_pkg::CFG_LEG_LIMIT:       cfg_reg.leg_limit       <= cfg_wdata;
                lppd_pkg::CFG_DETECTION_WIDTH: cfg_reg.detection_width <= cfg_wdata;
                lppd_pkg::CFG_DETECTION_DEPTH: cfg_reg.detection_depth <= cfg_wdata;
                lppd_pkg::CFG_BOUND_WIDTH:     cfg_reg.bound_width     <= cfg_wdata;
                lppd_pkg::CFG_BOUND_DEPTH:     cfg_reg.bound_depth     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // The front end stores blobs and walks the pairs, queuing every person that falls in
    // the detection window, then an end-of-frame marker with the overflow flag.
    lppd_front #(
        .MAX_BLOBS  (MAX_BLOBS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .blob_x    (blob_x),
        .blob_y    (blob_y),
        .last_blob (last_blob),
        .q_push    (q_push),
        .q_data    (q_wdata),
        .q_full    (q_full)
    );

    // A short queue lets the pair tester keep running while the CORDIC is busy.
    lppd_fifo #(
        .WIDTH (REC_W),
        .DEPTH (2)
    ) u_cand_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // The back end computes angle and magnitude, keeps the in-bound statistics and
    // writes the person and summary results.
    lppd_back #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_ITERS (CORDIC_ITERS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .o_push  (o_push),
        .o_data  (o_wdata),
        .o_full  (o_full)
    );

    // The result queue keeps finished results while the consumer stalls.
    lppd_fifo #(
        .WIDTH ($bits(lppd_pkg::result_t)),
        .DEPTH (2)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata (o_wdata),
        .full  (o_full),
        .pop   (pop),
        .rdata (o_rdata),
        .empty (empty)
    );

    assign kind           = o_rdata.kind;
    assign person_x       = o_rdata.person_x;
    assign person_y       = o_rdata.person_y;
    assign angle          = o_rdata.angle;
    assign magnitude      = o_rdata.magnitude;
    assign person_count   = o_rdata.person_count;
    assign count_in_bound = o_rdata.count_in_bound;
    assign closest_index  = o_rdata.closest_index;
    assign closest_valid  = o_rdata.closest_valid;
    assign overflow       = o_rdata.overflow;
    assign last           = o_rdata.last;

endmodule

### tb/lppd_checker.sv
`timescale 1ns / 1ps

module lppd_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  logic [9:0]         blob_x,
    input  logic [9:0]         blob_y,
    input  logic               last_blob,
    input  logic               empty,
    input  logic               pop,
    input  logic               kind,
    input  logic signed [23:0] person_x,
    input  logic signed [23:0] person_y,
    input  logic signed [15:0] angle,
    input  logic [23:0]        magnitude,
    input  logic [4:0]         person_count,
    input  logic [4:0]         count_in_bound,
    input  logic [4:0]         closest_index,
    input  logic               closest_valid,
    input  logic               overflow,
    input  logic               last,
    input  logic               cfg_we,
    input  logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lppd_pkg::CFG_W-1:0]     cfg_wdata,
    output int                 errors,
    output int                 pending
);

    localparam int NBLOB = 8;
    localparam int NPERS = 28;
    localparam int ITERS = 14;

    lppd_pkg::cfg_t    regs;
    logic [9:0]        xs [NBLOB];
    logic [9:0]        ys [NBLOB];
    int                n_blobs;
    bit                dropped;
    lppd_pkg::result_t frame_results [$];

    function automatic longint unsigned axis_gap(longint unsigned a, longint unsigned b);
        longint unsigned d;
        longint unsigned m;
        d = (a > b) ? a - b : b - a;
        m = (d * regs.scale_factor) >> 4;
        return (m > 64'hFFFFFF) ? 64'hFFFFFF : m;
    endfunction

    function automatic bit in_area(longint x, longint y, longint w, longint dep);
        return (2 * x >= -w) && (2 * x <= w) && (y >= 0) && (y <= dep);
    endfunction

    function automatic longint clip24(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // Vectoring rotation toward the forward axis; returns heading and range.
    task automatic polar(input longint x, input longint y, output int ang,
                         output longint mag);
        longint cx;
        longint cy;
        longint sx;
        longint sy;
        longint m;
        int     z;
        int     atan_q [ITERS];
        atan_q = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32, 16, 8, 4, 2};
        if (x == 0 && y == 0)
        begin
            ang = 0;
            mag = 0;
            return;
        end
        cx = y;
        cy = x;
        z  = 0;
        for (int i = 0; i < ITERS; i++)
        begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cy > 0)
            begin
                cx += sx;
                cy -= sy;
                z  += atan_q[i];
            end
            else
            begin
                cx -= sx;
                cy += sy;
                z  -= atan_q[i];
            end
        end
        if (z > 25736)
            z = 25736;
        if (z < -25736)
            z = -25736;
        m   = (cx < 0) ? 0 : ((cx * 39797 + 32768) >>> 16);
        ang = z;
        mag = (m > 64'hFFFFFF) ? 64'hFFFFFF : m;
    endtask

    // Stores one blob; on the frame's last blob, queues the persons and summary.
    task automatic take_blob(input logic [9:0] bx, input logic [9:0] by, input logic lb);
        longint unsigned   lim2;
        longint unsigned   half;
        longint unsigned   dx;
        longint unsigned   dy;
        longint unsigned   ax;
        longint unsigned   ay;
        longint unsigned   cx;
        longint unsigned   cy;
        longint            px;
        longint            py;
        longint            mag;
        longint            best_mag;
        int                ang;
        int                n;
        int                nb;
        int                best;
        bit                have;
        lppd_pkg::result_t r;
        if (n_blobs < NBLOB)
        begin
            xs[n_blobs] = bx;
            ys[n_blobs] = by;
            n_blobs++;
        end
        else
            dropped = 1'b1;
        if (!lb)
            return;
        lim2 = longint'(regs.leg_limit) * regs.leg_limit;
        half = regs.grid_size >> 1;
        n = 0;
        nb = 0;
        best = 0;
        have = 0;
        best_mag = 0;
        for (int i = 0; i < n_blobs; i++)
        begin
            for (int j = i + 1; j < n_blobs; j++)
            begin
                ax = xs[i];
                ay = ys[i];
                cx = xs[j];
                cy = ys[j];
                dx = axis_gap(ax, cx);
                dy = axis_gap(ay, cy);
                if (dx * dx + dy * dy >= lim2)
                    continue;
                px = longint'(half) - longint'(((ax + cx) * regs.scale_factor) >> 5);
                py = longint'(((ay + cy) * regs.scale_factor) >> 5) - longint'(half);
                if (!in_area(px, py, regs.detection_width, regs.detection_depth)
                    || n >= NPERS)
                    continue;
                polar(px, py, ang, mag);
                if (in_area(px, py, regs.bound_width, regs.bound_depth))
                begin
                    if (!have || mag < best_mag)
                    begin
                        have = 1;
                        best_mag = mag;
                        best = n;
                    end
                    nb++;
                end
                r = '0;
                r.person_x  = 24'(clip24(px));
                r.person_y  = 24'(clip24(py));
                r.angle     = 16'(ang);
                r.magnitude = 24'(mag);
                frame_results.insert(frame_results.size(), r);
                n++;
            end
        end
        r = '0;
        r.kind           = 1'b1;
        r.person_count   = 5'(n);
        r.count_in_bound = 5'(nb);
        r.closest_index  = have ? 5'(best) : 5'd0;
        r.closest_valid  = have;
        r.overflow       = dropped;
        r.last           = 1'b1;
        frame_results.insert(frame_results.size(), r);
        n_blobs = 0;
        dropped = 1'b0;
    endtask

    function automatic void compare(string field, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", field, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lppd_pkg::result_t e;
        if (!rst_n)
        begin
            regs = '0;
            regs.scale_factor = lppd_pkg::SCALE_RESET;
            n_blobs = 0;
            dropped = 1'b0;
            frame_results.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_results.size() == 0)
                begin
                    $error("result request with nothing expected");
                    errors++;
                end
                else
                begin
                    e = frame_results.pop_front();
                    compare("kind", e.kind, kind);
                    compare("person_x", e.person_x, person_x);
                    compare("person_y", e.person_y, person_y);
                    compare("angle", e.angle, angle);
                    compare("magnitude", e.magnitude, magnitude);
                    compare("person_count", e.person_count, person_count);
                    compare("count_in_bound", e.count_in_bound, count_in_bound);
                    compare("closest_index", e.closest_index, closest_index);
                    compare("closest_valid", e.closest_valid, closest_valid);
                    compare("overflow", e.overflow, overflow);
                    compare("last", e.last, last);
                end
            end
            if (push && !full)
                take_blob(blob_x, blob_y, last_blob);
            if (cfg_we)
            begin
                case (cfg_index)
                    lppd_pkg::CFG_SCALE_FACTOR:    regs.scale_factor    = cfg_wdata;
                    lppd_pkg::CFG_GRID_SIZE:       regs.grid_size       = cfg_wdata;
                    lppd_pkg::CFG_LEG_LIMIT:       regs.leg_limit       = cfg_wdata;
                    lppd_pkg::CFG_DETECTION_WIDTH: regs.detection_width = cfg_wdata;
                    lppd_pkg::CFG_DETECTION_DEPTH: regs.detection_depth = cfg_wdata;
                    lppd_pkg::CFG_BOUND_WIDTH:     regs.bound_width     = cfg_wdata;
                    lppd_pkg::CFG_BOUND_DEPTH:     regs.bound_depth     = cfg_wdata;
                    default:                       ;
                endcase
            end
            pending = frame_results.size();
        end
    end

endmodule

### tb/tb_leg_pair_person_detector.sv
`timescale 1ns / 1ps

// Top of the detector testbench. It drives blob requests and configuration writes,
// paces the result side, and prints the verdict. All prediction and comparison is
// done by the checker instance, which reports its failure count and how many result
// requests it still expects.
module tb_leg_pair_person_detector;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [9:0]         blob_x;
    logic [9:0]         blob_y;
    logic               last_blob;
    logic               empty;
    logic               pop;
    logic               kind;
    logic signed [23:0] person_x;
    logic signed [23:0] person_y;
    logic signed [15:0] angle;
    logic [23:0]        magnitude;
    logic [4:0]         person_count;
    logic [4:0]         count_in_bound;
    logic [4:0]         closest_index;
    logic               closest_valid;
    logic               overflow;
    logic               last;
    logic               cfg_we;
    logic [lppd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lppd_pkg::CFG_W-1:0]     cfg_wdata;

    int errors;
    int pending;

    // When calm is set neither side idles any more.
    bit calm;
    // Set by the stimulus to make the result side hold off for a long stretch.
    bit long_hold;

    leg_pair_person_detector u_dut (.*);

    lppd_checker u_checker (.*);

    // Distances in Q12.12 meters at unit scale; the grid is 1024 squares, centered at 512.
    localparam logic [lppd_pkg::CFG_W-1:0] GRID     = 24'd4194304;
    localparam logic [lppd_pkg::CFG_W-1:0] LEG_10M  = 24'd40960;
    localparam logic [lppd_pkg::CFG_W-1:0] LEG_6M   = 24'd24576;
    localparam logic [lppd_pkg::CFG_W-1:0] DET_W    = 24'd819200;
    localparam logic [lppd_pkg::CFG_W-1:0] DET_D    = 24'd2457600;
    localparam logic [lppd_pkg::CFG_W-1:0] BND_W    = 24'd163840;
    localparam logic [lppd_pkg::CFG_W-1:0] BND_D    = 24'd409600;
    // An index past the register list.
    localparam logic [lppd_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // The slowest correct run is far below this, even with every frame at full pairs.
    initial
    begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold while the sender keeps
    // offering requests so the block backs up and raises full.
    initial
    begin
        int stall_left;
        bit hold_seen;
        stall_left = 0;
        hold_seen = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_seen)
            begin
                hold_seen = 1;
                stall_left = 600;
            end
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic write_reg(input logic [lppd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lppd_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Loads a whole register setting; the block must be idle when this is called.
    task automatic load_setting(input logic [lppd_pkg::CFG_W-1:0] sf,
                                input logic [lppd_pkg::CFG_W-1:0] gs,
                                input logic [lppd_pkg::CFG_W-1:0] ld,
                                input logic [lppd_pkg::CFG_W-1:0] dw,
                                input logic [lppd_pkg::CFG_W-1:0] dd,
                                input logic [lppd_pkg::CFG_W-1:0] bw,
                                input logic [lppd_pkg::CFG_W-1:0] bd);
        write_reg(lppd_pkg::CFG_SCALE_FACTOR, sf);
        write_reg(lppd_pkg::CFG_GRID_SIZE, gs);
        write_reg(lppd_pkg::CFG_LEG_LIMIT, ld);
        write_reg(lppd_pkg::CFG_DETECTION_WIDTH, dw);
        write_reg(lppd_pkg::CFG_DETECTION_DEPTH, dd);
        write_reg(lppd_pkg::CFG_BOUND_WIDTH, bw);
        write_reg(lppd_pkg::CFG_BOUND_DEPTH, bd);
    endtask

    // Holds one blob request until the block takes it, then maybe idles a while.
    task automatic send_blob(input logic [9:0] x, input logic [9:0] y, input logic lb);
        int gap;
        @(negedge clk);
        push      <= 1'b1;
        blob_x    <= x;
        blob_y    <= y;
        last_blob <= lb;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic drop_push();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // Waits for every expected result, then lets the pair search finish any tail.
    task automatic drain();
        drop_push();
        while (pending != 0)
            @(posedge clk);
        repeat (700)
            @(posedge clk);
    endtask

    // A random frame: mostly blobs clustered around one point in front of the
    // sensor so pairs form persons, sometimes noise over the whole grid, and now
    // and then more blobs than the store holds.
    task automatic random_frame(output int sent);
        int nb;
        int cx;
        int cy;
        int spread;
        logic [9:0] x;
        logic [9:0] y;
        nb = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
        cx = $urandom_range(8, 1015);
        cy = $urandom_range(0, 4) == 0 ? $urandom_range(8, 1015) : $urandom_range(512, 1015);
        spread = $urandom_range(0, 8);
        for (int i = 0; i < nb; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                x = 10'($urandom);
                y = 10'($urandom);
            end
            else
            begin
                x = 10'(cx + $urandom_range(0, 2 * spread) - spread);
                y = 10'(cy + $urandom_range(0, 2 * spread) - spread);
            end
            send_blob(x, y, i == nb - 1);
        end
        sent = nb;
    endtask

    task automatic random_frames(input int items);
        int done;
        int sent;
        done = 0;
        while (done < items)
        begin
            random_frame(sent);
            done += sent;
        end
    endtask

    initial
    begin
        calm      = 0;
        long_hold = 0;
        push      = 1'b0;
        blob_x    = '0;
        blob_y    = '0;
        last_blob = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setting: the leg distance is zero, so frames give a summary only.
        send_blob(10'd0, 10'd0, 1'b1);
        send_blob(10'd1023, 10'd1023, 1'b0);
        send_blob(10'd1023, 10'd1023, 1'b1);
        drain();

        // Unit scale, grid centered at square 512, generous windows.
        load_setting(24'd65536, GRID, LEG_10M, DET_W, DET_D, BND_W, BND_D);
        // A write to an index past the register list is ignored.
        write_reg(CFG_SPARE, lppd_pkg::M24);
        // Person exactly at the origin.
        send_blob(10'd512, 10'd512, 1'b0);
        send_blob(10'd512, 10'd512, 1'b1);
        // Eight coincident blobs: every pair is a person, all outside the bound box, so none is nearest.
        for (int i = 0; i < 8; i++)
            send_blob(10'd600, 10'd530, i == 7);
        // Past capacity: the ninth to eleventh blobs are dropped.
        for (int i = 0; i < 11; i++)
            send_blob(10'(520 + i), 10'd700, i == 10);
        // Grid corners, far apart, and a pair outside the detection window.
        send_blob(10'd0, 10'd1023, 1'b0);
        send_blob(10'd1023, 10'd0, 1'b1);
        send_blob(10'd100, 10'd100, 1'b0);
        send_blob(10'd101, 10'd100, 1'b1);
        drain();

        // Long hold on the result side while blobs keep arriving.
        long_hold = 1;
        random_frames(20);
        // The sender pauses until everything outstanding has come back.
        drop_push();
        while (pending != 0)
            @(posedge clk);
        random_frames(5);
        drain();

        // Every register at its maximum: distances saturate, positions clip.
        load_setting(lppd_pkg::M24, lppd_pkg::M24, lppd_pkg::M24, lppd_pkg::M24,
                     lppd_pkg::M24, lppd_pkg::M24, lppd_pkg::M24);
        random_frames(10);
        drain();

        // Zero scale: every pair collapses onto the origin, windows are a point.
        load_setting(24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
        random_frames(10);
        drain();

        // A bound box of zero size, so a nearest person is reported only for one exactly at the origin.
        load_setting(24'd131072, GRID, LEG_6M, lppd_pkg::M24, lppd_pkg::M24, 24'd0, 24'd0);
        random_frames(5);
        drain();

        // Back to the usual setting; the tail of the run has no idling.
        load_setting(24'd65536, GRID, LEG_10M, DET_W, DET_D, BND_W, BND_D);
        random_frames(5);
        calm = 1;
        random_frames(5);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
